### src/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg
// Shared types and constants of the DC power meter front end.
// ----------------------------------------------------------------------------
package dpm_pkg;

  localparam int ADC_BITS   = 12;
  localparam int IN_TDATA_W = ((ADC_BITS + 7) / 8) * 8;
  localparam int DIFF_W     = ADC_BITS + 1;

  localparam int CUR_W  = 21;
  localparam int VOLT_W = 32;
  localparam int POW_W  = 56;

  localparam int OUT_FIELDS_W = ADC_BITS + CUR_W + VOLT_W + POW_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = 60;
  localparam int MAG_W   = 33;

  localparam int CUR_SHIFT  = 16;
  localparam int VOLT_SHIFT = 24;

  localparam logic [ADC_BITS-1:0] EMPTY_CODE   = ADC_BITS'(2048);
  localparam logic [ADC_BITS-1:0] OFFSET_RESET = ADC_BITS'(2060);

  localparam logic [23:0]        CUR_SCALE_RESET = 24'd261152;
  localparam logic [15:0]        CUR_BP_RESET    = 16'd1000;
  localparam logic [15:0]        CUR_DB_RESET    = 16'd40;
  localparam logic signed [24:0] VOLT_SCALE_RESET = -25'sd331361;
  localparam logic [15:0]        RATIO_RESET     = 16'd256;
  localparam logic [15:0]        VOLT_DB_RESET   = 16'd50;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUR_SCALE_LO = 3'd0,
    CFG_CUR_SCALE_HI = 3'd1,
    CFG_CUR_BP       = 3'd2,
    CFG_CUR_DB       = 3'd3,
    CFG_VOLT_SCALE   = 3'd4,
    CFG_RATIO        = 3'd5,
    CFG_VOLT_DB      = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIFF,
    S_MUL1,
    S_MUL2,
    S_ABS,
    S_CHK,
    S_RND,
    S_STO,
    S_PWR,
    S_DONE
  } dpm_state_e;

endpackage

### src/dpm_div.sv
// ----------------------------------------------------------------------------
// dpm_div
// Restoring divider, one quotient bit per cycle, for the burst mean.
// ----------------------------------------------------------------------------
module dpm_div #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;
  logic              fits;

  // remainder stays below the divisor, so one extra bit holds the trial
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (step_q != '0) begin
        step_d = step_q - STEP_W'(1);
        dvd_d  = {dvd_q[SUM_W-2:0], fits};
        rem_d  = fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = busy_q && (step_q == '0);
  assign quotient_o = dvd_q;

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  a_div_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("divider done held for two cycles");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");
`endif

endmodule

### src/dpm_mul.sv
// ----------------------------------------------------------------------------
// dpm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dpm_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [dpm_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [dpm_pkg::MUL_B_W-1:0] b_i,
  output logic signed [dpm_pkg::PROD_W-1:0]  p_o
);

  import dpm_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p_q;

  // operands sign-extend to the product width before the multiply
  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= prod;
    end
  end

  assign p_o = p_q;

endmodule

### src/dc_power_meter_front_end.sv
// ----------------------------------------------------------------------------
// dc_power_meter_front_end
// Burst averaging, tare and scaling of current and voltage ADC samples,
// with power from the newest voltage and current.
//
//   channel  dir  width     fields (low bit up)
//   s_axis   in   16/3/1    tdata: sample; tuser: mode, channel, sample_ok;
//                           tlast: last_sample
//   m_axis   out  128/2     tdata: average_code, current_ma, voltage_mv,
//                           power_uw; tuser: result_channel, tared
//   cfg      in   1/3/25    write enable, register index, write data
//
// Words without tlast are accumulated with tready high. After a last word
// tready stays low while the burst is finished: the bit-serial mean divider,
// skipped when no sample is good, then either the tare offset store or the
// shared multiplier and rounding steps, with a second current product when
// the high gain is needed, and last the power product and the final step.
// The result waits in an output register, so the next burst is taken while it
// is unread; a second finished burst holds in the final step until that
// register frees up.
// Reset clears all control state and loads the register and offset defaults.
// ----------------------------------------------------------------------------
module dc_power_meter_front_end #(
  parameter int MAX_SAMPLES = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dpm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // sample
  input  logic [2:0]                          s_axis_tuser,  // mode, channel, sample_ok
  input  logic                                s_axis_tlast,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // average_code, current_ma, voltage_mv, power_uw
  output logic [dpm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // result_channel, tared
  // configuration
  input  logic                                cfg_we_i,
  input  logic [dpm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dpm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  import dpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = ADC_BITS + CNT_W;

  // configuration registers
  logic [23:0]        cur_scale_lo_q, cur_scale_hi_q;
  logic [15:0]        cur_bp_q, cur_db_q, ratio_q, volt_db_q;
  logic signed [24:0] volt_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_scale_lo_q <= CUR_SCALE_RESET;
      cur_scale_hi_q <= CUR_SCALE_RESET;
      cur_bp_q       <= CUR_BP_RESET;
      cur_db_q       <= CUR_DB_RESET;
      volt_scale_q   <= VOLT_SCALE_RESET;
      ratio_q        <= RATIO_RESET;
      volt_db_q      <= VOLT_DB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CUR_SCALE_LO: cur_scale_lo_q <= cfg_wdata_i[23:0];
        CFG_CUR_SCALE_HI: cur_scale_hi_q <= cfg_wdata_i[23:0];
        CFG_CUR_BP:       cur_bp_q       <= cfg_wdata_i[15:0];
        CFG_CUR_DB:       cur_db_q       <= cfg_wdata_i[15:0];
        CFG_VOLT_SCALE:   volt_scale_q   <= $signed(cfg_wdata_i[24:0]);
        CFG_RATIO:        ratio_q        <= cfg_wdata_i[15:0];
        CFG_VOLT_DB:      volt_db_q      <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // input word
  logic                in_acc;
  logic                in_mode, in_chan, in_ok;
  logic [ADC_BITS-1:0] in_smp;

  assign in_mode = s_axis_tuser[0];
  assign in_chan = s_axis_tuser[1];
  assign in_ok   = s_axis_tuser[2];
  assign in_smp  = s_axis_tdata[ADC_BITS-1:0];

  // state
  dpm_state_e                state_q, state_d;
  logic [SUM_W-1:0]          sum_q, sum_d, sum_nxt;
  logic [CNT_W-1:0]          good_q, good_d, good_nxt;
  logic [CNT_W-1:0]          burst_q, burst_d;
  logic                      take;
  logic                      mode_q, mode_d, chan_q, chan_d;
  logic                      second_q, second_d;
  logic [ADC_BITS-1:0]       avg_q, avg_d;
  logic [ADC_BITS-1:0]       cur_off_q, cur_off_d, volt_off_q, volt_off_d;
  logic signed [DIFF_W-1:0]  d_q, d_d;
  logic [PROD_W-1:0]         mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic [MAG_W-1:0]          msat_q, msat_d;
  logic signed [CUR_W-1:0]   cur_q, cur_d;
  logic signed [VOLT_W-1:0]  volt_q, volt_d;
  logic                      out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]    out_data_q, out_data_d;
  logic [1:0]                out_user_q, out_user_d;

  // mean divider and shared multiplier
  logic                        div_start, div_done;
  logic [SUM_W-1:0]            div_quo;
  logic                        mul_en;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod;

  dpm_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_nxt),
    .divisor_i  (good_nxt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  dpm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // accumulation including the word on the bus
  assign take     = burst_q < CNT_W'(MAX_SAMPLES);
  assign sum_nxt  = (take && in_ok) ? sum_q + SUM_W'(in_smp) : sum_q;
  assign good_nxt = (take && in_ok) ? good_q + CNT_W'(1) : good_q;

  // rounding helpers
  logic [PROD_W:0]  rnd_sum;
  logic [PROD_W:0]  rnd_val;
  logic [MAG_W-1:0] lim;
  logic [MAG_W-1:0] neg_val;
  logic             in_db;

  always_comb begin
    if (chan_q) begin
      rnd_sum = {1'b0, mag_q} + ((PROD_W+1)'(1) << (VOLT_SHIFT - 1));
      rnd_val = rnd_sum >> VOLT_SHIFT;
      lim     = neg_q ? (MAG_W'(1) << (VOLT_W - 1))
                      : (MAG_W'(1) << (VOLT_W - 1)) - MAG_W'(1);
      in_db   = msat_q < MAG_W'(volt_db_q);
    end else begin
      rnd_sum = {1'b0, mag_q} + ((PROD_W+1)'(1) << (CUR_SHIFT - 1));
      rnd_val = rnd_sum >> CUR_SHIFT;
      lim     = neg_q ? (MAG_W'(1) << (CUR_W - 1))
                      : (MAG_W'(1) << (CUR_W - 1)) - MAG_W'(1);
      in_db   = msat_q < MAG_W'(cur_db_q);
    end
    neg_val = MAG_W'(0) - msat_q;
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    good_d      = good_q;
    burst_d     = burst_q;
    mode_d      = mode_q;
    chan_d      = chan_q;
    second_d    = second_q;
    avg_d       = avg_q;
    cur_off_d   = cur_off_q;
    volt_off_d  = volt_off_q;
    d_d         = d_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    msat_d      = msat_q;
    cur_d       = cur_q;
    volt_d      = volt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    div_start   = 1'b0;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tlast) begin
            sum_d   = '0;
            good_d  = '0;
            burst_d = '0;
            mode_d  = in_mode;
            chan_d  = in_chan;
            if (good_nxt == '0) begin
              avg_d   = EMPTY_CODE;
              state_d = S_DIFF;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else begin
            sum_d   = sum_nxt;
            good_d  = good_nxt;
            burst_d = take ? burst_q + CNT_W'(1) : burst_q;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_d   = div_quo[ADC_BITS-1:0];
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (mode_q) begin
          if (chan_q) begin
            volt_off_d = avg_q;
          end else begin
            cur_off_d = avg_q;
          end
          state_d = S_PWR;
        end else begin
          d_d = $signed({1'b0, avg_q}) -
                $signed({1'b0, chan_q ? volt_off_q : cur_off_q});
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        mul_en   = 1'b1;
        second_d = 1'b0;
        if (chan_q) begin
          // voltage: difference times ratio first, gain next
          mul_a   = MUL_A_W'(d_q);
          mul_b   = $signed(MUL_B_W'(ratio_q));
          state_d = S_MUL2;
        end else begin
          mul_a   = $signed(MUL_A_W'(cur_scale_lo_q));
          mul_b   = MUL_B_W'(d_q);
          state_d = S_ABS;
        end
      end
      S_MUL2: begin
        mul_en   = 1'b1;
        second_d = 1'b1;
        if (chan_q) begin
          mul_a = prod[MUL_A_W-1:0];
          mul_b = MUL_B_W'(volt_scale_q);
        end else begin
          mul_a = $signed(MUL_A_W'(cur_scale_hi_q));
          mul_b = MUL_B_W'(d_q);
        end
        state_d = S_ABS;
      end
      S_ABS: begin
        neg_d   = prod[PROD_W-1];
        mag_d   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        state_d = (!chan_q && !second_q) ? S_CHK : S_RND;
      end
      S_CHK: begin
        // breakpoint on the exact low-gain product
        state_d = (mag_q > (PROD_W'(cur_bp_q) << CUR_SHIFT)) ? S_MUL2 : S_RND;
      end
      S_RND: begin
        msat_d  = (rnd_val >= (PROD_W+1)'(lim)) ? lim : rnd_val[MAG_W-1:0];
        state_d = S_STO;
      end
      S_STO: begin
        if (chan_q) begin
          volt_d = in_db ? '0 : (neg_q ? neg_val[VOLT_W-1:0] : msat_q[VOLT_W-1:0]);
        end else begin
          cur_d = in_db ? '0 : (neg_q ? neg_val[CUR_W-1:0] : msat_q[CUR_W-1:0]);
        end
        state_d = S_PWR;
      end
      S_PWR: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(volt_q);
        mul_b   = MUL_B_W'(cur_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_TDATA_W'({prod[POW_W-1:0], volt_q, cur_q, avg_q});
          out_user_d  = {mode_q, chan_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      good_q      <= '0;
      burst_q     <= '0;
      second_q    <= 1'b0;
      cur_off_q   <= OFFSET_RESET;
      volt_off_q  <= OFFSET_RESET;
      cur_q       <= '0;
      volt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      good_q      <= good_d;
      burst_q     <= burst_d;
      second_q    <= second_d;
      cur_off_q   <= cur_off_d;
      volt_off_q  <= volt_off_d;
      cur_q       <= cur_d;
      volt_q      <= volt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    chan_q     <= chan_d;
    avg_q      <= avg_d;
    d_q        <= d_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    msat_q     <= msat_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q <= CNT_W'(MAX_SAMPLES))
    else $error("burst count beyond sample limit");

  a_good_le_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_q <= burst_q)
    else $error("good count exceeds burst count");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after last word of a burst");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final step");
`endif

endmodule
